### rtl/core/pbrld_pkg.sv
// Shared types and constants for the PackBits run-length decoder.
package pbrld_pkg;

    localparam int CAP_BITS        = 20;
    localparam int RUN_BITS        = 8;
    localparam int COUNT_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(48000);
    localparam logic [7:0]          HDR_NOP   = 8'd128;
    localparam logic [8:0]          REP_BASE  = 9'd257;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2,
        MODE_SKIP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_TRUNC    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       blob_end;
    } t_in;

    typedef struct packed {
        logic [7:0]          first_byte;
        logic [7:0]          second_byte;
        logic [1:0]          byte_count;
        logic                run_last;
        logic                stream_done;
        t_status             status;
        logic [CAP_BITS-1:0] decoded_total;
    } t_out;

    // One expansion request from the front to the back.
    typedef struct packed {
        logic [7:0]          data_byte;
        logic [RUN_BITS-1:0] count;      // 0 for a status-only request
        logic                done;
        t_status             status;
        logic [CAP_BITS-1:0] total;
    } t_cmd;

endpackage

### rtl/core/pbrld_front.sv
// Front end: header parsing, capacity check, run state and request generation.
module pbrld_front import pbrld_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_wdata,
    input  logic                i_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    localparam int CMP_BITS = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

    t_mode                 r_mode, n_mode, step_mode;
    logic [RUN_BITS-1:0]   r_run_left, n_run_left;
    logic [COUNT_BITS-1:0] r_bw, n_bw, step_bw;
    logic                  r_err, n_err, step_err;
    logic [CAP_BITS-1:0]   r_capacity;

    logic                  accept;
    logic                  is_lit, is_rep;
    logic [RUN_BITS-1:0]   hdr_cnt;
    logic [CMP_BITS-1:0]   cap_eff, cap_ext, mask_ext, need;
    logic                  fits;
    logic                  data_out;
    logic [CMP_BITS-1:0]   bw_ext;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    assign is_lit  = !i_in.code_byte[7];
    assign is_rep  = i_in.code_byte > HDR_NOP;
    assign hdr_cnt = i_in.code_byte[7] ? RUN_BITS'(REP_BASE - {1'b0, i_in.code_byte})
                                       : RUN_BITS'(i_in.code_byte + 8'd1);

    // Counter limit clamps a capacity wider than the byte counter.
    assign cap_ext  = CMP_BITS'(r_capacity);
    assign mask_ext = CMP_BITS'({COUNT_BITS{1'b1}});
    assign cap_eff  = (cap_ext > mask_ext) ? mask_ext : cap_ext;
    assign need     = CMP_BITS'(r_bw) + CMP_BITS'(hdr_cnt);
    assign fits     = need <= cap_eff;

    // Next state of the decode mode.
    always_comb begin
        step_mode = r_mode;
        unique case (r_mode)
            MODE_HEADER: begin
                if (is_lit || is_rep) begin
                    if (!fits)       step_mode = MODE_SKIP;
                    else if (is_lit) step_mode = MODE_LITERAL;
                    else             step_mode = MODE_REPEAT;
                end
            end
            MODE_LITERAL: begin
                if (r_run_left == RUN_BITS'(1)) step_mode = MODE_HEADER;
            end
            MODE_REPEAT: step_mode = MODE_HEADER;
            MODE_SKIP:   step_mode = MODE_SKIP;
            default:     step_mode = MODE_HEADER;
        endcase
        n_mode = r_mode;
        if (accept) n_mode = i_in.blob_end ? MODE_HEADER : step_mode;
    end

    // Run counters, byte count and the request to the back end.
    always_comb begin
        n_run_left = r_run_left;
        step_bw    = r_bw;
        step_err   = r_err;
        data_out   = 1'b0;
        o_cmd      = '0;
        o_cmd.data_byte = i_in.code_byte;
        unique case (r_mode)
            MODE_HEADER: begin
                if (is_lit || is_rep) begin
                    if (fits) n_run_left = hdr_cnt;
                    else      step_err   = 1'b1;
                end
            end
            MODE_LITERAL: begin
                data_out    = 1'b1;
                o_cmd.count = RUN_BITS'(1);
                step_bw     = r_bw + COUNT_BITS'(1);
                n_run_left  = r_run_left - RUN_BITS'(1);
            end
            MODE_REPEAT: begin
                data_out    = 1'b1;
                o_cmd.count = r_run_left;
                step_bw     = r_bw + COUNT_BITS'(r_run_left);
                n_run_left  = '0;
            end
            MODE_SKIP: ;
            default: ;
        endcase

        bw_ext = CMP_BITS'(step_bw);
        if (i_in.blob_end) begin
            o_cmd.done  = 1'b1;
            o_cmd.total = bw_ext[CAP_BITS-1:0];
            if (step_err)
                o_cmd.status = STATUS_OVERFLOW;
            else if (step_mode == MODE_LITERAL || step_mode == MODE_REPEAT)
                o_cmd.status = STATUS_TRUNC;
            else
                o_cmd.status = STATUS_OK;
        end

        o_push = accept && (data_out || i_in.blob_end);
        n_bw   = r_bw;
        n_err  = r_err;
        if (accept) begin
            n_bw  = i_in.blob_end ? '0 : step_bw;
            n_err = i_in.blob_end ? 1'b0 : step_err;
            if (i_in.blob_end) n_run_left = '0;
        end else begin
            n_run_left = r_run_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_HEADER;
            r_run_left <= '0;
            r_bw       <= '0;
            r_err      <= 1'b0;
            r_capacity <= CAP_RESET;
        end else begin
            r_mode     <= n_mode;
            r_run_left <= n_run_left;
            r_bw       <= n_bw;
            r_err      <= n_err;
            if (i_cfg_we) r_capacity <= i_cfg_wdata;
        end
    end

endmodule

### rtl/core/pbrld_queue.sv
// Small request queue between the front and back ends.
module pbrld_queue import pbrld_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_cmd                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_BITS'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + PTR_BITS'(1);
        if (i_pop)  n_rd = (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + PTR_BITS'(1);
        if (i_push && !i_pop)      n_cnt = r_cnt + CNT_BITS'(1);
        else if (!i_push && i_pop) n_cnt = r_cnt - CNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

### rtl/core/pbrld_back.sv
// Back end: expands requests into two-byte results behind an output register.
module pbrld_back import pbrld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic [RUN_BITS-1:0] r_sent, n_sent;
    logic                r_valid;
    t_out                r_out, n_out;
    logic                can_load, emit, last_chunk;
    logic [RUN_BITS-1:0] left;
    logic [1:0]          cnt;

    assign can_load   = !r_valid || i_out_ready;
    assign emit       = !i_empty && can_load;
    assign left       = i_head.count - r_sent;
    assign last_chunk = left <= RUN_BITS'(2);
    assign cnt        = last_chunk ? left[1:0] : 2'd2;
    assign o_pop      = emit && last_chunk;

    always_comb begin
        n_out             = '0;
        n_out.byte_count  = cnt;
        n_out.first_byte  = (cnt != 2'd0) ? i_head.data_byte : 8'd0;
        n_out.second_byte = (cnt == 2'd2) ? i_head.data_byte : 8'd0;
        n_out.run_last    = last_chunk;
        if (last_chunk && i_head.done) begin
            n_out.stream_done   = 1'b1;
            n_out.status        = i_head.status;
            n_out.decoded_total = i_head.total;
        end
        n_sent = r_sent;
        if (emit) n_sent = last_chunk ? '0 : r_sent + RUN_BITS'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            r_sent <= n_sent;
            if (can_load) r_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= n_out;
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/packbits_run_length_decoder.sv
// Top level of the streaming PackBits decoder.
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_ready     i_in  (code_byte, blob_end)
//   output    out        o_out_valid / i_out_ready   o_out (bytes, count, status)
//   config    in         i_cfg_we                    i_cfg_wdata (output capacity)
//
// Header and literal bytes are taken at one per cycle while the request queue
// has room; a literal byte passes through the queue and then the output register.
// A repeat run of n bytes leaves the back end as ceil(n/2) results; input
// stalls once the request queue (QUEUE_DEPTH entries) fills.
// Synchronous active-low reset; no clearing pass. Output stalls back up
// through the queue to o_in_ready without losing a request.
module packbits_run_length_decoder import pbrld_pkg::*; #(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in                 i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out                o_out,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_wdata
);

    logic push, pop, full, empty;
    t_cmd cmd, head;

    pbrld_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    pbrld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    pbrld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### rtl/core/pbrld_checker.sv
// Port-level checks for the PackBits decoder, bound to the top level.
module pbrld_checker import pbrld_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.stream_done |-> o_out.run_last)
        else $error("stream_done without run_last");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.stream_done |->
            o_out.status == STATUS_OK && o_out.decoded_total == '0)
        else $error("status fields set on a data result");

    a_empty_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.byte_count == 2'd0 |-> o_out.stream_done)
        else $error("empty result that is not the final status");

endmodule

bind packbits_run_length_decoder pbrld_checker u_pbrld_checker (.*);

### sim/tb_packbits_run_length_decoder.sv
// PackBits decoder testbench: directed and random blobs checked against a built-in model.
module tb_packbits_run_length_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import pbrld_pkg::*;

    localparam int                  QUIET_LIMIT   = 2000;
    localparam int                  SETTLE_CYCLES = QUEUE_DEPTH_DEF + 6;
    localparam int                  ITEM_TARGET   = 260;
    localparam int                  PRINT_LIMIT   = 40;
    localparam logic [CAP_BITS-1:0] CAP_MAX       = '1;
    localparam longint              COUNT_MAX     = (64'd1 << COUNT_BITS_DEF) - 1;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                req_valid = 1'b0;
    t_in                 req_data  = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                res_ready = 1'b0;
    t_out                o_out;
    logic                cfg_we    = 1'b0;
    logic [CAP_BITS-1:0] cfg_wdata = '0;

    packbits_run_length_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (req_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (res_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // decoder model state
    t_mode                     dec_mode      = MODE_HEADER;
    logic [RUN_BITS-1:0]       run_remaining = '0;
    logic [COUNT_BITS_DEF-1:0] written       = '0;
    logic                      overflowed    = 1'b0;
    logic [CAP_BITS-1:0]       capacity      = CAP_RESET;

    t_in        code_stream[$];
    t_out       due_results[$];
    logic [7:0] blob_bytes[$];

    int   mismatches     = 0;
    int   useful_items   = 0;
    int   requests_taken = 0;
    int   results_seen   = 0;
    int   blobs_done     = 0;
    int   overflow_blobs = 0;
    int   trunc_blobs    = 0;
    int   req_gap        = 0;
    int   res_stall      = 0;
    int   quiet_cycles   = 0;
    logic gaps_on        = 1'b1;

    function automatic t_out make_result(input logic [7:0] a_byte, b_byte, input int n);
        t_out r;
        r = '0;
        r.status = STATUS_OK;
        r.byte_count = 2'(n);
        if (n >= 1) r.first_byte = a_byte;
        if (n >= 2) r.second_byte = b_byte;
        return r;
    endfunction

    function automatic bit run_fits(input int cnt);
        longint lim;
        lim = longint'(capacity);
        if (lim > COUNT_MAX) lim = COUNT_MAX;
        return longint'(written) + longint'(cnt) <= lim;
    endfunction

    function automatic void expand_code_byte(input t_in req);
        t_out                batch[$];
        t_out                tail;
        int                  cnt;
        int                  left;
        t_status             st;
        logic [CAP_BITS-1:0] total;
        st = STATUS_OK;
        total = '0;
        case (dec_mode)
            MODE_HEADER: begin
                if (req.code_byte != HDR_NOP) begin
                    cnt = (req.code_byte < HDR_NOP) ? int'(req.code_byte) + 1
                                                    : int'(REP_BASE) - int'(req.code_byte);
                    if (run_fits(cnt)) begin
                        dec_mode = (req.code_byte < HDR_NOP) ? MODE_LITERAL : MODE_REPEAT;
                        run_remaining = RUN_BITS'(cnt);
                    end else begin
                        // whole run rejected, rest of blob is skipped
                        dec_mode = MODE_SKIP;
                        overflowed = 1'b1;
                    end
                end
            end
            MODE_LITERAL: begin
                batch.push_back(make_result(req.code_byte, 8'h00, 1));
                written = written + COUNT_BITS_DEF'(1);
                run_remaining = run_remaining - RUN_BITS'(1);
                if (run_remaining == '0) dec_mode = MODE_HEADER;
            end
            MODE_REPEAT: begin
                left = int'(run_remaining);
                while (left > 0) begin
                    cnt = (left >= 2) ? 2 : 1;
                    batch.push_back(make_result(req.code_byte, req.code_byte, cnt));
                    left -= cnt;
                end
                written = written + COUNT_BITS_DEF'(run_remaining);
                run_remaining = '0;
                dec_mode = MODE_HEADER;
            end
            default: ;
        endcase
        if (req.blob_end) begin
            if (overflowed) st = STATUS_OVERFLOW;
            else if (dec_mode == MODE_LITERAL || dec_mode == MODE_REPEAT) st = STATUS_TRUNC;
            total = CAP_BITS'(written);
            blobs_done++;
            if (st == STATUS_OVERFLOW) overflow_blobs++;
            if (st == STATUS_TRUNC) trunc_blobs++;
            dec_mode = MODE_HEADER;
            run_remaining = '0;
            written = '0;
            overflowed = 1'b0;
            if (batch.size() == 0) batch.push_back(make_result(8'h00, 8'h00, 0));
        end
        if (batch.size() > 0) begin
            tail = batch.pop_back();
            tail.run_last = 1'b1;
            if (req.blob_end) begin
                tail.stream_done = 1'b1;
                tail.status = st;
                tail.decoded_total = total;
            end
            batch.push_back(tail);
        end
        foreach (batch[k]) due_results.push_back(batch[k]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            if (mismatches < PRINT_LIMIT)
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && o_in_ready) begin
                if (dec_mode != MODE_SKIP) useful_items++;
                requests_taken++;
                expand_code_byte(req_data);
            end
            if (!req_valid || o_in_ready) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_valid <= 1'b0;
                end else if (code_stream.size() > 0) begin
                    req_data <= code_stream.pop_front();
                    req_valid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 4);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && res_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    if (mismatches < PRINT_LIMIT)
                        $display("%0t: result expected none got %h", $time, o_out);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("first_byte", 32'(want.first_byte), 32'(o_out.first_byte));
                    check_field("second_byte", 32'(want.second_byte),
                                32'(o_out.second_byte));
                    check_field("byte_count", 32'(want.byte_count), 32'(o_out.byte_count));
                    check_field("run_last", 32'(want.run_last), 32'(o_out.run_last));
                    check_field("stream_done", 32'(want.stream_done),
                                32'(o_out.stream_done));
                    check_field("status", 32'(want.status), 32'(o_out.status));
                    check_field("decoded_total", 32'(want.decoded_total),
                                32'(o_out.decoded_total));
                end
            end
            if (res_stall > 0) begin
                res_stall--;
                res_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 6) == 0) begin
                res_stall = $urandom_range(0, 3);
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_valid && o_in_ready) || (o_out_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog, no handshake for %0d cycles, %0d results pending",
                         $time, quiet_cycles, due_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (code_stream.size() > 0 || req_valid || due_results.size() > 0);
    endtask

    task automatic set_capacity(input logic [CAP_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        capacity = value;
        @(negedge i_clk);
    endtask

    // queue blob_bytes as one blob; optionally hold the sender halfway until all results are in
    task automatic send_blob(input bit pause_mid);
        t_in item;
        for (int k = 0; k < blob_bytes.size(); k++) begin
            if (pause_mid && k > 0 && k == blob_bytes.size() / 2) wait_drained();
            item.code_byte = blob_bytes[k];
            item.blob_end = (k == blob_bytes.size() - 1);
            code_stream.push_back(item);
        end
    endtask

    task automatic build_random_blob();
        int len;
        int cut;
        blob_bytes.delete();
        if ($urandom_range(0, 14) == 0) begin
            // plain noise
            len = $urandom_range(1, 6);
            repeat (len) blob_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        len = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 128)
                                                           : $urandom_range(1, 6);
                        blob_bytes.push_back(8'(len - 1));
                        repeat (len) blob_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    9: blob_bytes.push_back(HDR_NOP);
                    default: begin
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 128)
                                                          : $urandom_range(2, 9);
                        blob_bytes.push_back(8'(int'(REP_BASE) - len));
                        blob_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            // cut some blobs short so they end inside a run
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, blob_bytes.size());
                while (blob_bytes.size() > cut) void'(blob_bytes.pop_back());
            end
        end
    endtask

    initial begin : stimulus
        logic [CAP_BITS-1:0] phase_caps[4];
        int                  goal;
        bit                  first_blob;
        phase_caps[0] = CAP_MAX;
        phase_caps[1] = CAP_BITS'($urandom_range(1, 40));
        phase_caps[2] = CAP_BITS'($urandom_range(100, 700));
        phase_caps[3] = CAP_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed blobs at the reset capacity
        blob_bytes = '{8'h00, 8'hFF, HDR_NOP, 8'hFE, 8'h55};
        send_blob(1'b0);
        blob_bytes = '{8'h81, 8'h00, HDR_NOP};      // longest repeat, header ends blob
        send_blob(1'b0);
        blob_bytes = '{8'h7F, 8'h12, 8'h34};        // longest literal, cut short
        send_blob(1'b0);
        blob_bytes = '{8'hFF};                      // repeat header as last byte
        send_blob(1'b0);
        blob_bytes = '{8'h01, 8'hAB, 8'hCD};
        send_blob(1'b0);
        blob_bytes = '{HDR_NOP};
        send_blob(1'b0);

        // zero capacity: every run overflows
        set_capacity('0);
        blob_bytes = '{8'h00, 8'h11, 8'h81, 8'h22};
        send_blob(1'b0);
        blob_bytes = '{HDR_NOP};
        send_blob(1'b0);
        blob_bytes = '{8'hFF};                      // overflow wins over truncation
        send_blob(1'b0);
        blob_bytes = '{8'h05, 8'h01};
        send_blob(1'b0);

        for (int p = 0; p < 4; p++) begin
            set_capacity(phase_caps[p]);
            gaps_on = (p < 3);
            goal = requests_taken + ITEM_TARGET / 4;
            first_blob = 1'b1;
            while (requests_taken < goal) begin
                while (code_stream.size() > 8) @(negedge i_clk);
                build_random_blob();
                send_blob(first_blob);
                first_blob = 1'b0;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (due_results.size() > 0) begin
            $display("%0t: %0d results expected but never seen", $time, due_results.size());
            mismatches++;
        end
        $display("Decoded %0d requests (%0d outside overflow skips) in %0d blobs, %0d results checked, %0d mismatches.",
                 requests_taken, useful_items, blobs_done, results_seen, mismatches);
        $display("Blobs ending in overflow: %0d, truncated: %0d; capacity from 0 to %0d.",
                 overflow_blobs, trunc_blobs, CAP_MAX);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/pbrld_pkg.sv
rtl/core/pbrld_front.sv
rtl/core/pbrld_queue.sv
rtl/core/pbrld_back.sv
rtl/core/packbits_run_length_decoder.sv
rtl/core/pbrld_checker.sv
sim/tb_packbits_run_length_decoder.sv
